>>> rtl/vertex_normal_accumulate_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the vertex normal accumulate unit
// Each macro is one clocked property with an active-low disable.
// ---------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATE_UNIT_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define VNACC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VNACC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vnacc_pkg.sv
// ---------------------------------------------------------------------------
// vnacc_pkg
// Shared types and constants of the vertex normal accumulate unit.
// ---------------------------------------------------------------------------
package vnacc_pkg;

    localparam int CFG_W       = 11;
    localparam int VTX_W       = 10;
    localparam int POS_FIELD_W = 24;
    localparam int CORNER_W    = 16;
    localparam int NRM_W       = 16;
    localparam int ACC_W       = 56;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TRI  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd_code;

    // Work classes handed from front to back.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TRI,
        OP_READ,
        OP_READ_ZERO
    } t_op;

    typedef struct packed {
        logic [1:0]                    command;
        logic [VTX_W-1:0]              vertex_index;
        logic signed [POS_FIELD_W-1:0] pos_x;
        logic signed [POS_FIELD_W-1:0] pos_y;
        logic signed [POS_FIELD_W-1:0] pos_z;
        logic [CORNER_W-1:0]           corner_a;
        logic [CORNER_W-1:0]           corner_b;
        logic [CORNER_W-1:0]           corner_c;
    } t_in_item;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [VTX_W-1:0]        normal_vertex;
        logic                    zero_length;
    } t_out_item;

    typedef struct packed {
        t_op                     op;
        logic [VTX_W-1:0]        vertex_index;
        logic [POS_FIELD_W-1:0]  pos_x;
        logic [POS_FIELD_W-1:0]  pos_y;
        logic [POS_FIELD_W-1:0]  pos_z;
        logic [CORNER_W-1:0]     corner_a;
        logic [CORNER_W-1:0]     corner_b;
        logic [CORNER_W-1:0]     corner_c;
    } t_qentry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRD_B,
        S_PRD_C,
        S_EDGE,
        S_MUL,
        S_CROSS_LAST,
        S_ACC_RD,
        S_ACC_WR,
        S_RD_MAG,
        S_NORM,
        S_SQ,
        S_SQ_LAST,
        S_SQRT,
        S_DIV_LD,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

>>> rtl/vnacc_front.sv
// ---------------------------------------------------------------------------
// vnacc_front
// Holds vertex_count, classifies items and drops the ones with no effect.
// ---------------------------------------------------------------------------
module vnacc_front #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [vnacc_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  vnacc_pkg::t_in_item        i_in_item,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output vnacc_pkg::t_qentry         o_q_data
);
    import vnacc_pkg::*;

    logic [CFG_W-1:0] r_vertex_count;
    logic             accept;
    logic             vi_ok;
    logic             tri_ok;
    logic             keep;
    t_op              op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    assign accept = i_in_valid && !i_q_full;
    assign vi_ok  = 32'(i_in_item.vertex_index) < 32'(MAX_VERTICES);

    // A corner must be below both the live count and the store depth.
    assign tri_ok = (32'(i_in_item.corner_a) < 32'(r_vertex_count))
                 && (32'(i_in_item.corner_b) < 32'(r_vertex_count))
                 && (32'(i_in_item.corner_c) < 32'(r_vertex_count))
                 && (32'(i_in_item.corner_a) < 32'(MAX_VERTICES))
                 && (32'(i_in_item.corner_b) < 32'(MAX_VERTICES))
                 && (32'(i_in_item.corner_c) < 32'(MAX_VERTICES));

    always_comb begin
        keep = 1'b0;
        op   = OP_LOAD;
        unique case (t_cmd_code'(i_in_item.command))
            CMD_LOAD: begin
                keep = vi_ok;
                op   = OP_LOAD;
            end
            CMD_TRI: begin
                keep = tri_ok;
                op   = OP_TRI;
            end
            CMD_READ: begin
                keep = 1'b1;
                op   = vi_ok ? OP_READ : OP_READ_ZERO;
            end
            CMD_NOP: begin
                keep = 1'b0;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall             = i_q_full;
    assign o_q_push               = accept && keep;
    assign o_q_data.op            = op;
    assign o_q_data.vertex_index  = i_in_item.vertex_index;
    assign o_q_data.pos_x         = i_in_item.pos_x;
    assign o_q_data.pos_y         = i_in_item.pos_y;
    assign o_q_data.pos_z         = i_in_item.pos_z;
    assign o_q_data.corner_a      = i_in_item.corner_a;
    assign o_q_data.corner_b      = i_in_item.corner_b;
    assign o_q_data.corner_c      = i_in_item.corner_c;

endmodule

>>> rtl/vnacc_fifo.sv
// ---------------------------------------------------------------------------
// vnacc_fifo
// Short command queue between front and back.
// ---------------------------------------------------------------------------
module vnacc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  vnacc_pkg::t_qentry i_data,
    input  logic               i_pop,
    output vnacc_pkg::t_qentry o_data,
    output logic               o_full,
    output logic               o_empty
);
    import vnacc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qentry          r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/vnacc_back.sv
// ---------------------------------------------------------------------------
// vnacc_back
// Position and accumulator stores, triangle accumulate, normalize sequencer.
// ---------------------------------------------------------------------------
`include "vertex_normal_accumulate_unit_assert.svh"

module vnacc_back #(
    parameter int MAX_VERTICES = 1024,
    parameter int POS_WIDTH    = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  vnacc_pkg::t_qentry   i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output vnacc_pkg::t_out_item o_out_item
);
    import vnacc_pkg::*;

    localparam int AW       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int PW       = POS_WIDTH;
    localparam int EW       = PW + 1;
    localparam int PROD_W   = 2 * EW;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int SUM_W    = ((CROSS_W > ACC_W) ? CROSS_W : ACC_W) + 1;
    localparam int TOP_W    = SUM_W - ACC_W + 1;
    localparam int NM_W     = 31;
    localparam int SQ_W     = 2 * NM_W;
    localparam int V_W      = 64;
    localparam int LEN_W    = 32;
    localparam int FRAC_W   = 15;
    localparam int Q_W      = 17;
    localparam int NUM_W    = NM_W + FRAC_W + 1;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = Q_W;
    localparam logic [4:0] SQRT_LAST = 5'(SQRT_STEPS - 1);
    localparam logic [4:0] DIV_LAST  = 5'(DIV_STEPS - 1);
    localparam logic [ACC_W-1:0] ACC_MAX_V = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN_V = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [NRM_W-1:0] NRM_MAX_V = {1'b0, {(NRM_W-1){1'b1}}};

    // stores
    logic [3*PW-1:0]    mem_pos [MAX_VERTICES];
    logic [3*ACC_W-1:0] mem_acc [MAX_VERTICES];
    logic [3*PW-1:0]    r_pos_q;
    logic [3*ACC_W-1:0] r_acc_q;

    // control
    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic [4:0] r_it, n_it;
    t_qentry    r_cmd;

    // datapath
    logic signed [PW-1:0]      r_pa [3];
    logic signed [PW-1:0]      r_pb [3];
    logic signed [EW-1:0]      r_e1 [3];
    logic signed [EW-1:0]      r_e2 [3];
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic signed [CROSS_W-1:0] r_f [3];
    logic [2:0]                r_neg;
    logic [ACC_W-1:0]          r_mag [3];
    logic [SQ_W-1:0]           r_sq;
    logic [V_W-1:0]            r_len2;
    logic [V_W-1:0]            r_root;
    logic [V_W-1:0]            r_bit;
    logic [LEN_W-1:0]          r_rem;
    logic [Q_W-1:0]            r_num_lo;
    logic [Q_W-1:0]            r_q;
    logic [NRM_W-1:0]          r_res [3];
    logic                      r_zero;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    // FSM outputs
    logic             pos_we;
    logic             acc_we;
    logic [AW-1:0]    pos_wr_addr;
    logic [AW-1:0]    pos_rd_addr;
    logic [AW-1:0]    acc_rd_addr;
    logic [AW-1:0]    acc_wr_addr;
    logic [3*PW-1:0]  pos_wr_data;
    logic [3*ACC_W-1:0] acc_wr_data;
    logic             out_load;
    logic             out_free;

    // combinational helpers
    logic signed [PW-1:0]      pos_q [3];
    logic [ACC_W-1:0]          acc_raw [3];
    logic [3*ACC_W-1:0]        sat_word;
    logic signed [CROSS_W-1:0] cross_diff;
    logic signed [EW-1:0]      mul_a1, mul_b1, mul_a2, mul_b2;
    logic [ACC_W-1:0]          mag_or;
    logic                      norm_big;
    logic                      norm_low;
    logic [CORNER_W-1:0]       corner_sel;
    logic [AW-1:0]             corner_addr;
    logic [V_W-1:0]            sqrt_t;
    logic [LEN_W-1:0]          len;
    logic [NUM_W-1:0]          num;
    logic [LEN_W:0]            rem2;
    logic                      div_ge;
    logic [Q_W-1:0]            q_next;

    function automatic logic [NRM_W-1:0] scale_q(input logic neg, input logic [Q_W-1:0] q);
        logic [Q_W-1:0] nq;
        nq = Q_W'(~q + Q_W'(1));
        if (neg) begin
            return nq[NRM_W-1:0];
        end else if (q > Q_W'(NRM_MAX_V)) begin
            return NRM_MAX_V;
        end
        return q[NRM_W-1:0];
    endfunction

    function automatic logic [PW-1:0] pos_bits(input logic [POS_FIELD_W-1:0] f);
        logic [31:0] w;
        w = 32'(f);
        return w[PW-1:0];
    endfunction

    // ---------------------------------------------------------------- helpers
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pos_q[k]   = $signed(r_pos_q[k*PW +: PW]);
            acc_raw[k] = r_acc_q[k*ACC_W +: ACC_W];
        end
    end

    // saturating accumulate of the cross product
    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic [TOP_W-1:0]        top;
        sat_word = '0;
        for (int k = 0; k < 3; k++) begin
            s   = SUM_W'($signed(acc_raw[k])) + SUM_W'(r_f[k]);
            top = s[SUM_W-1:ACC_W-1];
            if ((&top) || (~|top)) begin
                sat_word[k*ACC_W +: ACC_W] = s[ACC_W-1:0];
            end else begin
                sat_word[k*ACC_W +: ACC_W] = s[SUM_W-1] ? ACC_MIN_V : ACC_MAX_V;
            end
        end
    end

    // component k: e1[k+1]*e2[k+2] - e1[k+2]*e2[k+1]
    always_comb begin
        case (r_cnt)
            2'd0: begin
                mul_a1 = r_e1[1]; mul_b1 = r_e2[2]; mul_a2 = r_e1[2]; mul_b2 = r_e2[1];
            end
            2'd1: begin
                mul_a1 = r_e1[2]; mul_b1 = r_e2[0]; mul_a2 = r_e1[0]; mul_b2 = r_e2[2];
            end
            default: begin
                mul_a1 = r_e1[0]; mul_b1 = r_e2[1]; mul_a2 = r_e1[1]; mul_b2 = r_e2[0];
            end
        endcase
    end

    assign cross_diff = CROSS_W'(r_p1) - CROSS_W'(r_p2);

    always_comb begin
        case (r_cnt)
            2'd0:    corner_sel = r_cmd.corner_a;
            2'd1:    corner_sel = r_cmd.corner_b;
            default: corner_sel = r_cmd.corner_c;
        endcase
    end
    assign corner_addr = AW'(32'(corner_sel));

    assign mag_or   = r_mag[0] | r_mag[1] | r_mag[2];
    assign norm_big = |mag_or[ACC_W-1:NM_W];
    assign norm_low = !mag_or[NM_W-1];

    assign sqrt_t = r_root + r_bit;
    assign len    = r_root[LEN_W-1:0];
    assign num    = NUM_W'({r_mag[r_cnt][NM_W-1:0], {FRAC_W{1'b0}}}) + NUM_W'(len >> 1);
    assign rem2   = {r_rem, r_num_lo[Q_W-1]};
    assign div_ge = rem2 >= {1'b0, len};
    assign q_next = {r_q[Q_W-2:0], div_ge};

    assign out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_it    = r_it;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.op)
                        OP_LOAD:      n_state = S_IDLE;
                        OP_TRI:       n_state = S_PRD_B;
                        OP_READ:      n_state = S_RD_MAG;
                        OP_READ_ZERO: n_state = S_EMIT;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_PRD_B: n_state = S_PRD_C;
            S_PRD_C: n_state = S_EDGE;
            S_EDGE: begin
                n_state = S_MUL;
                n_cnt   = 2'd0;
            end
            S_MUL: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = S_CROSS_LAST;
                end
            end
            S_CROSS_LAST: begin
                n_state = S_ACC_RD;
                n_cnt   = 2'd0;
            end
            S_ACC_RD: n_state = S_ACC_WR;
            S_ACC_WR: begin
                if (r_cnt == 2'd2) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ACC_RD;
                    n_cnt   = r_cnt + 2'd1;
                end
            end
            S_RD_MAG: begin
                n_state = (r_acc_q == '0) ? S_EMIT : S_NORM;
            end
            S_NORM: begin
                if (!norm_big && !norm_low) begin
                    n_state = S_SQ;
                    n_cnt   = 2'd0;
                end
            end
            S_SQ: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = S_SQ_LAST;
                end
            end
            S_SQ_LAST: begin
                n_state = S_SQRT;
                n_it    = '0;
            end
            S_SQRT: begin
                n_it = r_it + 5'd1;
                if (r_it == SQRT_LAST) begin
                    n_state = S_DIV_LD;
                    n_cnt   = 2'd0;
                end
            end
            S_DIV_LD: begin
                n_state = S_DIV;
                n_it    = '0;
            end
            S_DIV: begin
                n_it = r_it + 5'd1;
                if (r_it == DIV_LAST) begin
                    if (r_cnt == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_DIV_LD;
                        n_cnt   = r_cnt + 2'd1;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------- FSM outputs
    always_comb begin
        o_pop       = 1'b0;
        pos_we      = 1'b0;
        acc_we      = 1'b0;
        out_load    = 1'b0;
        pos_wr_addr = AW'(32'(i_head.vertex_index));
        pos_wr_data = {pos_bits(i_head.pos_z), pos_bits(i_head.pos_y), pos_bits(i_head.pos_x)};
        pos_rd_addr = AW'(32'(r_cmd.corner_c));
        acc_rd_addr = corner_addr;
        acc_wr_addr = corner_addr;
        acc_wr_data = sat_word;
        unique case (r_state)
            S_IDLE: begin
                o_pop       = i_head_valid;
                pos_we      = i_head_valid && (i_head.op == OP_LOAD);
                acc_we      = pos_we;
                pos_rd_addr = AW'(32'(i_head.corner_a));
                acc_rd_addr = AW'(32'(i_head.vertex_index));
                acc_wr_addr = AW'(32'(i_head.vertex_index));
                acc_wr_data = '0;
            end
            S_PRD_B:  pos_rd_addr = AW'(32'(r_cmd.corner_b));
            S_ACC_WR: acc_we      = 1'b1;
            S_EMIT:   out_load    = out_free;
            default: begin
            end
        endcase
    end

    // -------------------------------------------------------------- stores
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            mem_pos[pos_wr_addr] <= pos_wr_data;
        end
        r_pos_q <= mem_pos[pos_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            mem_acc[acc_wr_addr] <= acc_wr_data;
        end
        r_acc_q <= mem_acc[acc_rd_addr];
    end

    // ------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_it        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_it    <= n_it;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    r_cmd <= i_head;
                    if (i_head.op == OP_READ_ZERO) begin
                        r_res[0] <= '0;
                        r_res[1] <= '0;
                        r_res[2] <= '0;
                        r_zero   <= 1'b1;
                    end
                end
            end
            S_PRD_B: begin
                for (int k = 0; k < 3; k++) r_pa[k] <= pos_q[k];
            end
            S_PRD_C: begin
                for (int k = 0; k < 3; k++) r_pb[k] <= pos_q[k];
            end
            S_EDGE: begin
                for (int k = 0; k < 3; k++) begin
                    r_e1[k] <= EW'(r_pb[k]) - EW'(r_pa[k]);
                    r_e2[k] <= EW'(pos_q[k]) - EW'(r_pa[k]);
                end
            end
            S_MUL: begin
                r_p1 <= mul_a1 * mul_b1;
                r_p2 <= mul_a2 * mul_b2;
                if (r_cnt != 2'd0) begin
                    r_f[2'(r_cnt - 2'd1)] <= cross_diff;
                end
            end
            S_CROSS_LAST: r_f[2] <= cross_diff;
            S_RD_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= acc_raw[k][ACC_W-1];
                    r_mag[k] <= acc_raw[k][ACC_W-1] ? ACC_W'(~acc_raw[k] + ACC_W'(1))
                                                    : acc_raw[k];
                end
                if (r_acc_q == '0) begin
                    r_res[0] <= '0;
                    r_res[1] <= '0;
                    r_res[2] <= '0;
                    r_zero   <= 1'b1;
                end else begin
                    r_zero <= 1'b0;
                end
            end
            S_NORM: begin
                // common shift, one bit a cycle, until the largest sits in [2^30, 2^31)
                for (int k = 0; k < 3; k++) begin
                    if (norm_big) begin
                        r_mag[k] <= r_mag[k] >> 1;
                    end else if (norm_low) begin
                        r_mag[k] <= r_mag[k] << 1;
                    end
                end
            end
            S_SQ: begin
                r_sq <= r_mag[r_cnt][NM_W-1:0] * r_mag[r_cnt][NM_W-1:0];
                if (r_cnt == 2'd0) begin
                    r_len2 <= '0;
                end else begin
                    r_len2 <= r_len2 + V_W'(r_sq);
                end
            end
            S_SQ_LAST: begin
                r_len2 <= r_len2 + V_W'(r_sq);
                r_root <= '0;
                r_bit  <= V_W'(1) << (V_W - 2);
            end
            S_SQRT: begin
                if (r_len2 >= sqrt_t) begin
                    r_len2 <= r_len2 - sqrt_t;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DIV_LD: begin
                r_rem    <= LEN_W'(num[NUM_W-1:Q_W]);
                r_num_lo <= num[Q_W-1:0];
                r_q      <= '0;
            end
            S_DIV: begin
                r_rem    <= div_ge ? LEN_W'(rem2 - {1'b0, len}) : rem2[LEN_W-1:0];
                r_num_lo <= r_num_lo << 1;
                r_q      <= q_next;
                if (r_it == DIV_LAST) begin
                    r_res[r_cnt] <= scale_q(r_neg[r_cnt], q_next);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.normal_x      <= r_res[0];
            r_out_item.normal_y      <= r_res[1];
            r_out_item.normal_z      <= r_res[2];
            r_out_item.normal_vertex <= r_cmd.vertex_index;
            r_out_item.zero_length   <= r_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ----------------------------------------------------------- assertions
    `VNACC_ASSERT_IMPLIES(a_zero_flag_clean, i_clk, i_rst_n, r_out_valid && r_out_item.zero_length, (r_out_item.normal_x == '0) && (r_out_item.normal_y == '0) && (r_out_item.normal_z == '0), "zero-length result carries a nonzero normal")
    `VNACC_ASSERT_IMPLIES(a_norm_window, i_clk, i_rst_n, (r_state == S_SQ) && (r_cnt == 2'd0), !norm_big && !norm_low, "magnitudes left normalize out of window")
    `VNACC_ASSERT_IMPLIES(a_quot_bound, i_clk, i_rst_n, (r_state == S_DIV) && (r_it == DIV_LAST), q_next <= Q_W'(32768), "normalized quotient above unit")
    `VNACC_ASSERT_NEXT(a_emit_to_idle, i_clk, i_rst_n, out_load, (r_state == S_IDLE) && r_out_valid, "result load did not release the sequencer")

endmodule

>>> rtl/vertex_normal_accumulate_unit.sv
// ---------------------------------------------------------------------------
// vertex_normal_accumulate_unit
// Area-weighted vertex normals: position load, triangle accumulate, and
// normalized read-back in Q1.15.
// ---------------------------------------------------------------------------
//
//  channel   signals                              transaction when
//  --------  -----------------------------------  ------------------------
//  in        i_in_valid / o_in_stall / i_in_item  valid high, stall low
//  out       o_out_valid / i_out_stall / o_out_item  valid high, stall low
//  cfg       i_cfg_we / i_cfg_wdata               write enable high
//
//  Load: written from the idle state as it is popped. Triangle: pop, 3
//  position reads, edges, 2-multiplier cross product plus a drain step,
//  3 accumulator read-modify-writes. Read: accumulator read, the
//  one-bit-a-cycle normalize shift, then 32 square-root steps and three
//  17-step restoring divides, then any output stall; a zero accumulator
//  goes straight to the result; dropped items never reach the sequencer.
//  Reset is synchronous, active low; stores are not cleared (load clears an
//  accumulator). A two-entry queue lets the front keep taking transactions,
//  while it has room, as the sequencer works or the result register stalls.
// ---------------------------------------------------------------------------
module vertex_normal_accumulate_unit #(
    parameter int MAX_VERTICES = 1024,
    parameter int POS_WIDTH    = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vnacc_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  vnacc_pkg::t_in_item         i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output vnacc_pkg::t_out_item        o_out_item
);
    import vnacc_pkg::*;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    t_qentry q_in;
    t_qentry q_head;

    // Front: config register, range checks, drop of no-op items.
    vnacc_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    vnacc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: stores and the multi-cycle sequencer, with the result register.
    vnacc_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .POS_WIDTH    (POS_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule
